// ===== rtl/s2da_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2da_pkg
// Shared types, constants and helpers of the signed integer to decimal text
// unit.
// ----------------------------------------------------------------------------
package s2da_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned CharW   = 8;
  localparam int unsigned PowIdxW = 3;   // selects one of five powers of ten
  localparam int unsigned PowW    = 14;  // wide enough for 10000
  localparam int unsigned ProdW   = 17;  // wide enough for 9 * 10000

  localparam logic [CharW-1:0]   DigitBase = 8'd48;  // '0'
  localparam logic [CharW-1:0]   MinusChar = 8'd45;  // '-'
  localparam logic [PowIdxW-1:0] PowIdxTop = 3'd4;   // index of 10000
  localparam logic [PowIdxW-1:0] PowIdxOne = 3'd0;   // index of 1

  // One queued item: sign, magnitude and the index of its leading digit.
  typedef struct packed {
    logic                neg;
    logic [ValueW-1:0]   mag;
    logic [PowIdxW-1:0]  pidx;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } back_state_e;

  function automatic logic [PowW-1:0] pow_of(input logic [PowIdxW-1:0] idx);
    logic [PowW-1:0] p;
    case (idx)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/s2da_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2da_front
// Accepts a value, splits it into sign and magnitude and finds the power of
// ten of its leading digit, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module s2da_front (
  input  wire logic                          start_i,
  input  wire logic [s2da_pkg::ValueW-1:0]   value_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output s2da_pkg::entry_t                   entry_o
);
  import s2da_pkg::*;

  logic [ValueW-1:0] mag;

  // Two's complement negate; -32768 comes out as the unsigned 32768.
  assign mag    = value_i[ValueW-1] ? (~value_i + 16'd1) : value_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    entry_o.neg = value_i[ValueW-1];
    entry_o.mag = mag;
    if (mag >= 16'd10000) begin
      entry_o.pidx = PowIdxTop;
    end else if (mag >= 16'd1000) begin
      entry_o.pidx = 3'd3;
    end else if (mag >= 16'd100) begin
      entry_o.pidx = 3'd2;
    end else if (mag >= 16'd10) begin
      entry_o.pidx = 3'd1;
    end else begin
      entry_o.pidx = PowIdxOne;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/s2da_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2da_queue
// Two-entry queue of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module s2da_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  s2da_pkg::entry_t       entry_i,
  input  wire logic              pop_i,
  output s2da_pkg::entry_t       head_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import s2da_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/s2da_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s2da_back
// Takes one item from the queue and sends its text, one character a cycle:
// an optional minus sign, then one digit per power of ten down to one.
// ----------------------------------------------------------------------------
module s2da_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  s2da_pkg::entry_t                 head_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  output logic                             char_valid_o,
  output logic [s2da_pkg::CharW-1:0]       character_o,
  output logic                             last_o
);
  import s2da_pkg::*;

  back_state_e        state_q, state_d;
  logic [ValueW-1:0]  mag_q, mag_d;
  logic [PowIdxW-1:0] pidx_q, pidx_d;
  logic               valid_q, valid_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;

  logic [PowW-1:0]    pow;
  logic [9:1]         ge;
  logic [3:0]         digit;
  logic [ProdW-1:0]   prod;
  logic [ValueW-1:0]  rem;

  // The digit is the largest k with k * pow <= mag; all nine compares run
  // side by side.
  always_comb begin
    pow   = pow_of(pidx_q);
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      ge[k] = ({1'b0, mag_q} >= (17'(k) * 17'(pow)));
      if (ge[k]) begin
        digit = 4'(k);
      end
    end
    prod = 17'(digit) * 17'(pow);
    rem  = mag_q - prod[ValueW-1:0];
  end

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    pidx_d  = pidx_q;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          mag_d   = head_i.mag;
          pidx_d  = head_i.pidx;
          state_d = head_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = MinusChar;
        last_d  = 1'b0;
        state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        valid_d = 1'b1;
        char_d  = DigitBase + {4'd0, digit};
        last_d  = (pidx_q == PowIdxOne);
        mag_d   = rem;
        if (pidx_q == PowIdxOne) begin
          state_d = ST_IDLE;
        end else begin
          pidx_d = pidx_q - 3'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    pidx_q <= pidx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign char_valid_o = valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Prints a signed 16-bit value as decimal ASCII text, one character a cycle within each value's text.
// ----------------------------------------------------------------------------
//  Channel  | Ports                            | Taken when
//  ---------+----------------------------------+------------------------------
//  value    | start_i, value_i, busy_o         | start_i high and busy_o low
//  text     | char_valid_o, character_o, last_o| every cycle char_valid_o is 1
//
// A value enters a two-entry queue in the cycle it is taken; busy_o is high
// only while that queue is full. The back end takes an item from the queue in
// its idle state and then sends one character per cycle, one to six per value.
// When the back end is free, the first character passes from the queue through
// its idle state and its sign or digit state to the output registers. Results
// cannot be stalled. Reset empties the queue and returns the back end to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [s2da_pkg::ValueW-1:0] value_i,
  output logic                             busy_o,
  output logic                             char_valid_o,
  output logic [s2da_pkg::CharW-1:0]       character_o,
  output logic                             last_o
);
  import s2da_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  assign busy_o = full;

  s2da_front u_front (
    .start_i (start_i),
    .value_i (value_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  s2da_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  s2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  // A minus sign never ends a run of text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && (character_o == MinusChar)) |-> !last_o)
    else $error("minus sign flagged as last character");

  // Every character sent is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> ((character_o == MinusChar) ||
                      ((character_o >= DigitBase) && (character_o <= 8'd57))))
    else $error("character outside minus sign and digits");

  // After the last digit the back end returns to idle before the next item.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_o) |=> !char_valid_o)
    else $error("character sent right after last digit");

  // The queue never takes an item while full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !push)
    else $error("item pushed into a full queue");

endmodule
`default_nettype wire

// ===== sim/signed_int_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Self-checking bench for the decimal text unit. A driver feeds signed values
// from a queue through the start/busy handshake. Each accepted value is
// turned into its expected run of characters, and a monitor compares every
// strobed character and last flag against the oldest expected character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

  import s2da_pkg::ValueW;
  import s2da_pkg::CharW;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandItems   = 330;
  localparam int unsigned ShowErrors  = 10;

  localparam logic [CharW-1:0] ZeroCode  = 8'd48;
  localparam logic [CharW-1:0] MinusCode = 8'd45;

  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start_i = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy_o;
  logic              char_valid_o;
  logic [CharW-1:0]  character_o;
  logic              last_o;

  logic [ValueW-1:0] value_q[$];
  text_char_t        text_q[$];
  int unsigned       accepted = 0;
  int unsigned       errors   = 0;
  int unsigned       cycles   = 0;

  signed_int_to_decimal_ascii_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .char_valid_o(char_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Appends the decimal text of one value to the expected characters.
  function automatic void push_decimal_text(input logic [ValueW-1:0] val);
    text_char_t  ch;
    int unsigned mag;
    int unsigned pw;
    int unsigned digit;
    pw = 10000;
    if (val[ValueW-1]) begin
      // The magnitude is unsigned, so the most negative value gives 32768.
      mag     = (32'h10000 - int'(val)) & 32'hFFFF;
      ch.code = MinusCode;
      ch.last = 1'b0;
      text_q.push_back(ch);
    end else begin
      mag = 32'(val);
    end
    while (pw > 1 && pw > mag) pw = pw / 10;
    do begin
      digit   = mag / pw;
      mag     = mag % pw;
      pw      = pw / 10;
      ch.code = ZeroCode + CharW'(digit % 10);
      ch.last = (pw == 0);
      text_q.push_back(ch);
    end while (pw != 0);
  endfunction

  // Value of a random length: one to five digits, either sign.
  function automatic logic [ValueW-1:0] sized_value();
    int lo;
    int hi;
    int mag;
    int digits;
    bit neg;
    digits = $urandom_range(1, 5);
    neg    = 1'($urandom_range(0, 1));
    lo     = (digits == 1) ? 0 : 10 ** (digits - 1);
    hi     = (digits == 5) ? (neg ? 32768 : 32767) : 10 ** digits - 1;
    mag    = $urandom_range(hi, lo);
    return ValueW'(neg ? -mag : mag);
  endfunction

  initial begin
    int unsigned directed[] = '{0, 1, 16'hFFFF, 9, 10, 16'hFFF6, 99, 100, 999, 1000,
                                9999, 10000, 32767, 16'h8000, 16'h8001, 12345,
                                16'hFFF7, 5, 90, 16'hFF9C, 16'hD8F0, 16'h5555,
                                16'hAAAA, 16'h7FFE};
    foreach (directed[i]) value_q.push_back(ValueW'(directed[i]));
    for (int i = 0; i < RandItems; i++) begin
      if ($urandom_range(0, 3) == 0) value_q.push_back(ValueW'($urandom));
      else value_q.push_back(sized_value());
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: holds an item until the unit takes it, idles now and then.
  always @(posedge clk_i) begin
    logic              nxt_start;
    logic [ValueW-1:0] nxt_value;
    bit                quiet;
    bit                idle;
    if (rst_ni) begin
      nxt_start = start_i;
      nxt_value = value_i;
      if (start_i && !busy_o) begin
        push_decimal_text(value_i);
        void'(value_q.pop_front());
        accepted++;
        nxt_start = 1'b0;
      end
      quiet = (accepted >= 150 && accepted < 230);
      idle  = !quiet && ($urandom_range(0, 99) < 10);
      if (!nxt_start && value_q.size() != 0 && !idle) begin
        nxt_start = 1'b1;
        nxt_value = value_q[0];
      end
      start_i <= nxt_start;
      value_i <= nxt_value;
    end
  end

  // Monitor: every strobed character must match the oldest expected one.
  always @(posedge clk_i) begin
    text_char_t exp_ch;
    if (rst_ni && char_valid_o) begin
      if (text_q.size() == 0) begin
        errors++;
        if (errors <= ShowErrors)
          $display("unexpected character %0d last %0b", character_o, last_o);
      end else begin
        exp_ch = text_q.pop_front();
        if (exp_ch.code !== character_o || exp_ch.last !== last_o) begin
          errors++;
          if (errors <= ShowErrors)
            $display("mismatch: expected character %0d last %0b, got %0d last %0b",
                     exp_ch.code, exp_ch.last, character_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("signed_int_to_decimal_ascii_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    do @(posedge clk_i); while (!rst_ni || value_q.size() != 0 || start_i);
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii_unit_tb: clean");
    end else begin
      $display("signed_int_to_decimal_ascii_unit_tb: errors");
    end
    $finish;
  end

endmodule
